// ===== rtl/taa_nc_pkg.sv =====
`timescale 1ns / 1ps
// taa_nc_pkg: sizes, register codes, pixel/column types and min/max helpers
// for the 3x3 neighbourhood clamp. No dependencies.
package taa_nc_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int CHANNEL_BITS  = 16;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);

    localparam int FW_BITS       = 12;
    localparam int FH_BITS       = 13;
    localparam int HW_BITS       = 9;
    localparam int ROW_BITS      = FH_BITS + 1;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = FH_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HISTORY_WEIGHT = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam int WEIGHT_SHIFT = HW_BITS - 1;
    localparam logic [HW_BITS-1:0] WEIGHT_ONE = HW_BITS'(1 << WEIGHT_SHIFT);

    localparam int NUM_CELLS = 3;

    typedef logic [CHANNEL_BITS-1:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_pix;

    localparam int PIX_BITS = $bits(t_pix);

    // one window column: rows above/at/below centre, plus centre history
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
        t_pix hist;
    } t_column;

    typedef struct packed {
        logic produce;
        logic col0;
        logic left_ctr;
        logic top_clamp;
        logic bot_clamp;
        logic eof;
    } t_flags;

    function automatic t_pix pix_min(t_pix a, t_pix b);
        t_pix r;
        r.red   = (a.red   < b.red)   ? a.red   : b.red;
        r.green = (a.green < b.green) ? a.green : b.green;
        r.blue  = (a.blue  < b.blue)  ? a.blue  : b.blue;
        return r;
    endfunction

    function automatic t_pix pix_max(t_pix a, t_pix b);
        t_pix r;
        r.red   = (a.red   > b.red)   ? a.red   : b.red;
        r.green = (a.green > b.green) ? a.green : b.green;
        r.blue  = (a.blue  > b.blue)  ? a.blue  : b.blue;
        return r;
    endfunction

endpackage

// ===== rtl/taa_nc_ram.sv =====
`timescale 1ns / 1ps
// taa_nc_ram: generic single-write, single-read RAM with registered read.
// Read during write to the same address returns the old contents. No dependencies.
module taa_nc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/taa_nc_cell.sv =====
`timescale 1ns / 1ps
// taa_nc_cell: one column of the 3x3 window; holds the column, hands it on
// to its neighbour on shift, and gives its per-channel min/max. Uses taa_nc_pkg.
module taa_nc_cell
    import taa_nc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_shift,
    input  t_column i_col,
    output t_column o_col,
    output t_pix    o_lo,
    output t_pix    o_hi
);

    t_column r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
    assign o_lo  = pix_min(pix_min(r_col.top, r_col.mid), r_col.bot);
    assign o_hi  = pix_max(pix_max(r_col.top, r_col.mid), r_col.bot);

endmodule

// ===== rtl/taa_nc_blend.sv =====
`timescale 1ns / 1ps
// taa_nc_blend: one colour channel: clamp history to [lo, hi], weighted blend
// with the current value, round and saturate. Three register stages. Uses taa_nc_pkg.
module taa_nc_blend
    import taa_nc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  t_chan              i_lo,
    input  t_chan              i_hi,
    input  t_chan              i_cur,
    input  t_chan              i_hist,
    input  logic [HW_BITS-1:0] i_weight,
    output t_chan              o_val
);

    localparam int PROD_BITS = CHANNEL_BITS + HW_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int SHR_BITS  = SUM_BITS - WEIGHT_SHIFT;
    localparam logic [SUM_BITS-1:0] ROUND = SUM_BITS'(1 << (WEIGHT_SHIFT - 1));

    t_chan                r_lo;
    t_chan                r_hi;
    t_chan                r_cur_a;
    t_chan                r_hist_a;
    t_chan                r_cur_b;
    t_chan                r_clamp_b;
    logic [PROD_BITS-1:0] r_prod_cur;
    logic [PROD_BITS-1:0] r_prod_hist;

    t_chan                n_clamp;
    logic [HW_BITS-1:0]   w_inv;
    logic [SUM_BITS-1:0]  w_sum;
    logic [SHR_BITS-1:0]  w_shr;

    always_comb begin
        n_clamp = r_hist_a;
        if (n_clamp < r_lo) begin
            n_clamp = r_lo;
        end
        if (n_clamp > r_hi) begin
            n_clamp = r_hi;
        end
    end

    assign w_inv = WEIGHT_ONE - i_weight;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo        <= i_lo;
            r_hi        <= i_hi;
            r_cur_a     <= i_cur;
            r_hist_a    <= i_hist;
            r_cur_b     <= r_cur_a;
            r_clamp_b   <= n_clamp;
            r_prod_cur  <= PROD_BITS'(r_cur_b) * PROD_BITS'(w_inv);
            r_prod_hist <= PROD_BITS'(r_clamp_b) * PROD_BITS'(i_weight);
        end
    end

    assign w_sum = SUM_BITS'(r_prod_cur) + SUM_BITS'(r_prod_hist) + ROUND;
    assign w_shr = w_sum[SUM_BITS-1:WEIGHT_SHIFT];
    assign o_val = (|w_shr[SHR_BITS-1:CHANNEL_BITS]) ? '1 : w_shr[CHANNEL_BITS-1:0];

endmodule

// ===== rtl/temporal_aa_neighborhood_clamp.sv =====
`timescale 1ns / 1ps
// temporal_aa_neighborhood_clamp: 3x3 neighbourhood-clamp temporal AA top level.
// Line stores, window cell chain and blend pipeline. Uses taa_nc_pkg,
// taa_nc_ram, taa_nc_cell, taa_nc_blend.
//
//   channel   direction  handshake                 payload
//   cfg       in         i_cfg_wr_en               i_cfg_idx, i_cfg_wdata
//   in        in         i_in_valid / o_in_stall   i_kind, i_cur_*, i_hist_*
//   out       out        o_out_valid / i_out_stall o_out_*, o_end_of_frame
//
// One transaction per clock unless the output stalls; the output is registered.
// A result belongs to the pixel one line plus one pixel earlier in the stream.
// Line stores have a single read and write port each; a neighbour-column bypass
// covers a write and a read of the same column in one clock.
// Synchronous active-low reset clears counters and valids, presets the config.
// A stall with output valid freezes the whole pipeline; o_in_stall follows it.
module temporal_aa_neighborhood_clamp
    import taa_nc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_kind,
    input  logic [CHANNEL_BITS-1:0]  i_cur_red,
    input  logic [CHANNEL_BITS-1:0]  i_cur_green,
    input  logic [CHANNEL_BITS-1:0]  i_cur_blue,
    input  logic [CHANNEL_BITS-1:0]  i_hist_red,
    input  logic [CHANNEL_BITS-1:0]  i_hist_green,
    input  logic [CHANNEL_BITS-1:0]  i_hist_blue,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CHANNEL_BITS-1:0]  o_out_red,
    output logic [CHANNEL_BITS-1:0]  o_out_green,
    output logic [CHANNEL_BITS-1:0]  o_out_blue,
    output logic                     o_end_of_frame
);

    localparam int CELL_C = 0;
    localparam int CELL_B = 1;
    localparam int CELL_A = 2;

    // configuration
    logic [COL_BITS-1:0] r_w_last;
    logic [ROW_BITS-1:0] r_height;
    logic [HW_BITS-1:0]  r_weight;

    // position
    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] r_row;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;
    logic r_eof3, r_eof4, r_eof5, r_out_eof;
    logic r_byp;

    // stage payload
    logic                r_pix1;
    t_pix                r_cur1;
    t_pix                r_hist1;
    logic [COL_BITS-1:0] r_col1;
    t_flags              r_f1;
    t_flags              r_f2;
    t_pix                r_byp_up;
    t_pix                r_byp_md;
    t_pix                r_byp_hh;
    t_chan               r_out_red;
    t_chan               r_out_green;
    t_chan               r_out_blue;

    logic w_en, w_accept, w_pix, w_in_rows, w_take, w_load, w_we, w_shift;
    t_pix w_cur_in, w_hist_in;
    t_flags w_flags;

    logic [COL_BITS-1:0] n_w_last;
    logic [ROW_BITS-1:0] n_height;
    logic [HW_BITS-1:0]  n_weight;
    logic [FW_BITS-1:0]  w_cfg_fw;
    logic [FH_BITS-1:0]  w_cfg_fh;
    logic [HW_BITS-1:0]  w_cfg_hw;

    logic [PIX_BITS-1:0] w_rd_up, w_rd_md, w_rd_hh;
    t_pix w_up, w_md, w_hh;
    t_column w_col_new;

    t_column w_cell_d [NUM_CELLS];
    t_column w_cell_q [NUM_CELLS];
    t_pix    w_cell_lo [NUM_CELLS];
    t_pix    w_cell_hi [NUM_CELLS];

    t_pix w_lo_l, w_lo_r, w_hi_l, w_hi_r, w_win_lo, w_win_hi, w_ctr, w_ctr_hist;
    t_chan w_blend_red, w_blend_green, w_blend_blue;

    // handshake
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;
    assign w_accept   = i_in_valid && w_en;
    assign w_pix      = (i_kind == KIND_PIXEL);
    assign w_in_rows  = r_row < r_height;
    assign w_take     = (w_pix && w_in_rows) || (i_kind == KIND_FLUSH && !w_in_rows);
    assign w_load     = w_accept && w_take;

    always_comb begin
        w_cur_in.red    = i_cur_red;
        w_cur_in.green  = i_cur_green;
        w_cur_in.blue   = i_cur_blue;
        w_hist_in.red   = i_hist_red;
        w_hist_in.green = i_hist_green;
        w_hist_in.blue  = i_hist_blue;
    end

    always_comb begin
        w_flags.produce   = (r_row > ROW_BITS'(1)) ||
                            (r_row == ROW_BITS'(1) && r_col != '0);
        w_flags.col0      = (r_col == '0);
        w_flags.left_ctr  = (r_col == COL_BITS'(1)) || (r_col == '0 && r_w_last == '0);
        w_flags.top_clamp = (r_row == ROW_BITS'(1));
        w_flags.bot_clamp = (r_row == r_height);
        w_flags.eof       = (r_row > r_height);
    end

    // register saturation
    assign w_cfg_fw = i_cfg_wdata[FW_BITS-1:0];
    assign w_cfg_fh = i_cfg_wdata[FH_BITS-1:0];
    assign w_cfg_hw = i_cfg_wdata[HW_BITS-1:0];

    always_comb begin
        if (w_cfg_fw == '0) begin
            n_w_last = '0;
        end else if (int'(w_cfg_fw) > MAX_WIDTH) begin
            n_w_last = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            n_w_last = COL_BITS'(w_cfg_fw - 1'b1);
        end
        n_height = (w_cfg_fh == '0) ? ROW_BITS'(1) : ROW_BITS'(w_cfg_fh);
        n_weight = (w_cfg_hw > WEIGHT_ONE) ? WEIGHT_ONE : w_cfg_hw;
    end

    // configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= COL_BITS'(1919);
            r_height <= ROW_BITS'(1080);
            r_weight <= HW_BITS'(230);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_w_last <= n_w_last;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_height <= n_height;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                CFG_HISTORY_WEIGHT: begin
                    r_weight <= n_weight;
                end
                default: begin
                end
            endcase
        end else if (w_load) begin
            if (r_row > r_height) begin
                r_col <= '0;
                r_row <= '0;
            end else if (r_col == r_w_last) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // pipeline valids and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
            r_eof3      <= 1'b0;
            r_eof4      <= 1'b0;
            r_eof5      <= 1'b0;
            r_out_eof   <= 1'b0;
            r_byp       <= 1'b0;
        end else if (w_en) begin
            r_v1        <= w_load;
            r_v2        <= r_v1;
            r_v3        <= r_v2 && r_f2.produce;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= r_v5;
            r_eof3      <= r_f2.eof;
            r_eof4      <= r_eof3;
            r_eof5      <= r_eof4;
            r_out_eof   <= r_eof5;
            if (w_load) begin
                r_byp <= w_we && (r_col1 == r_col);
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pix1      <= w_pix;
            r_cur1      <= w_cur_in;
            r_hist1     <= w_hist_in;
            r_col1      <= r_col;
            r_f1        <= w_flags;
            r_f2        <= r_f1;
            r_out_red   <= w_blend_red;
            r_out_green <= w_blend_green;
            r_out_blue  <= w_blend_blue;
            if (w_load) begin
                r_byp_up <= w_md;
                r_byp_md <= r_cur1;
                r_byp_hh <= r_hist1;
            end
        end
    end

    // line stores and history delay
    assign w_we = w_en && r_v1 && r_pix1;

    taa_nc_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_col1),
        .i_wdata (w_md),
        .i_re    (w_load),
        .i_raddr (r_col),
        .o_rdata (w_rd_up)
    );

    taa_nc_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_col1),
        .i_wdata (r_cur1),
        .i_re    (w_load),
        .i_raddr (r_col),
        .o_rdata (w_rd_md)
    );

    taa_nc_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_history_delay (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_col1),
        .i_wdata (r_hist1),
        .i_re    (w_load),
        .i_raddr (r_col),
        .o_rdata (w_rd_hh)
    );

    assign w_up = r_byp ? r_byp_up : t_pix'(w_rd_up);
    assign w_md = r_byp ? r_byp_md : t_pix'(w_rd_md);
    assign w_hh = r_byp ? r_byp_hh : t_pix'(w_rd_hh);

    // new column, edge rows repeated
    always_comb begin
        w_col_new.top  = r_f1.top_clamp ? w_md : w_up;
        w_col_new.mid  = w_md;
        w_col_new.bot  = r_f1.bot_clamp ? w_md : r_cur1;
        w_col_new.hist = w_hh;
    end

    // window cell chain
    assign w_shift     = w_en && r_v1;
    assign w_cell_d[0] = w_col_new;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign w_cell_d[g] = w_cell_q[g-1];
        end
        taa_nc_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_col   (w_cell_d[g]),
            .o_col   (w_cell_q[g]),
            .o_lo    (w_cell_lo[g]),
            .o_hi    (w_cell_hi[g])
        );
    end

    // window min/max, edge columns repeated
    always_comb begin
        w_lo_r     = r_f2.col0     ? w_cell_lo[CELL_B] : w_cell_lo[CELL_C];
        w_hi_r     = r_f2.col0     ? w_cell_hi[CELL_B] : w_cell_hi[CELL_C];
        w_lo_l     = r_f2.left_ctr ? w_cell_lo[CELL_B] : w_cell_lo[CELL_A];
        w_hi_l     = r_f2.left_ctr ? w_cell_hi[CELL_B] : w_cell_hi[CELL_A];
        w_win_lo   = pix_min(pix_min(w_lo_l, w_cell_lo[CELL_B]), w_lo_r);
        w_win_hi   = pix_max(pix_max(w_hi_l, w_cell_hi[CELL_B]), w_hi_r);
        w_ctr      = w_cell_q[CELL_B].mid;
        w_ctr_hist = w_cell_q[CELL_B].hist;
    end

    taa_nc_blend u_blend_red (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lo     (w_win_lo.red),
        .i_hi     (w_win_hi.red),
        .i_cur    (w_ctr.red),
        .i_hist   (w_ctr_hist.red),
        .i_weight (r_weight),
        .o_val    (w_blend_red)
    );

    taa_nc_blend u_blend_green (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lo     (w_win_lo.green),
        .i_hi     (w_win_hi.green),
        .i_cur    (w_ctr.green),
        .i_hist   (w_ctr_hist.green),
        .i_weight (r_weight),
        .o_val    (w_blend_green)
    );

    taa_nc_blend u_blend_blue (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lo     (w_win_lo.blue),
        .i_hi     (w_win_hi.blue),
        .i_cur    (w_ctr.blue),
        .i_hist   (w_ctr_hist.blue),
        .i_weight (r_weight),
        .o_val    (w_blend_blue)
    );

    assign o_out_valid    = r_out_valid;
    assign o_out_red      = r_out_red;
    assign o_out_green    = r_out_green;
    assign o_out_blue     = r_out_blue;
    assign o_end_of_frame = r_out_eof;

    // checks
    a_col_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_w_last)
        else $error("column counter beyond line width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_height + ROW_BITS'(1))
        else $error("row counter beyond flush row");

    a_bypass_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> (r_w_last == '0))
        else $error("line store bypass taken with width above one");

endmodule
